// File: hdl/bsc_pkg.sv
// ============================================================================
// bsc_pkg
// Types and constants shared by the deadlock-avoidance check unit.
// ============================================================================
package bsc_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;
    // The spare code behaves as a check.
    localparam logic [1:0] OP_SPARE   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVER_NEED  = 3'd1;
    localparam logic [2:0] ST_OVER_AVAIL = 3'd2;
    localparam logic [2:0] ST_UNSAFE     = 3'd3;
    localparam logic [2:0] ST_BAD_LOAD   = 3'd4;

    localparam logic [7:0] RESET_TOTAL_A = 8'd10;
    localparam logic [7:0] RESET_TOTAL_B = 8'd5;
    localparam logic [7:0] RESET_TOTAL_C = 8'd7;

    localparam logic [1:0] REG_TOTAL_A = 2'd0;
    localparam logic [1:0] REG_TOTAL_B = 2'd1;
    localparam logic [1:0] REG_TOTAL_C = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] process_id;
        logic [7:0] amount_a;
        logic [7:0] amount_b;
        logic [7:0] amount_c;
        logic [7:0] held_a;
        logic [7:0] held_b;
        logic [7:0] held_c;
    } bsc_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] safe_order;
        logic [3:0]  order_length;
    } bsc_result_t;

endpackage

// File: hdl/bankers_safety_check_unit.sv
// ============================================================================
// bankers_safety_check_unit
// Banker's deadlock-avoidance engine for three resource types. Held and
// need rows live in one synchronous memory; a sequencer scans it.
// ============================================================================
//  channel   signals                         direction
//  item      start, busy, item               in
//  result    result_valid, result            out (one cycle, no stall)
//  config    psel..pready, paddr, pwdata     APB slave
//
// A load is busy for one cycle. A request or check sums held over all rows
// (one row a cycle); a request that asks too much ends there. Otherwise the
// memory is scanned one row at a time, reading the row and then comparing
// it, as the single read port allows; the scan restarts at row 0 after every
// completion. The result strobe comes in the first cycle with busy low.
// Reset clears the tables through valid bits (cleared at once), no sweep.
// busy is high from the accepted item until its result strobe; results
// cannot be stalled.
module bankers_safety_check_unit #(
    parameter int PROCESSES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bsc_pkg::bsc_item_t    item,
    output logic                  result_valid,
    output bsc_pkg::bsc_result_t  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import bsc_pkg::*;

    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam logic [PW-1:0] LAST = PW'(PROCESSES - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_SUMW  = 4'd2;
    localparam logic [3:0] S_REQ   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_ROLL  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_RDREQ = 4'd8;

    // Row: held a,b,c then need a,b,c.
    logic [47:0] mem [PROCESSES];
    logic [PROCESSES-1:0] valid_reg;
    logic [47:0] rd_raw;
    logic        rd_ok_reg;
    logic [47:0] row;
    logic [PW-1:0] rd_addr;
    logic        wr_en;
    logic [PW-1:0] wr_addr;
    logic [47:0] wr_data;

    logic [7:0] total_reg [3];
    logic [3:0] state_reg;
    bsc_item_t  item_reg;
    logic [PW-1:0] idx_reg;
    logic signed [11:0] avail_reg [3];
    logic signed [11:0] work_reg [3];
    logic [PROCESSES-1:0] fin_reg;
    logic [23:0] order_reg;
    logic [3:0]  len_reg;
    logic [2:0]  status_reg;
    logic        res_v_reg;
    logic [PW-1:0] pid;

    assign pid = item_reg.process_id[PW-1:0];
    assign row = rd_ok_reg ? rd_raw : 48'd0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= valid_reg[rd_addr] && !(wr_en && wr_addr == rd_addr);
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[3:2])
            REG_TOTAL_A: prdata = {24'd0, total_reg[0]};
            REG_TOTAL_B: prdata = {24'd0, total_reg[1]};
            REG_TOTAL_C: prdata = {24'd0, total_reg[2]};
            default:     prdata = 32'd0;
        endcase
    end

    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    logic id_ok, load_bad, fits, over_need, over_avail;
    logic [7:0] amt [3];
    logic [7:0] hld [3];
    assign amt[0] = item_reg.amount_a;
    assign amt[1] = item_reg.amount_b;
    assign amt[2] = item_reg.amount_c;
    assign hld[0] = item_reg.held_a;
    assign hld[1] = item_reg.held_b;
    assign hld[2] = item_reg.held_c;
    assign id_ok  = {1'b0, item_reg.process_id} < 4'(PROCESSES);
    assign load_bad = !id_ok || hld[0] > amt[0] || hld[1] > amt[1] || hld[2] > amt[2];

    always_comb
    begin
        fits = 1'b1;
        over_need = 1'b0;
        over_avail = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if ($signed({4'd0, row[23-8*k -: 8]}) > work_reg[k])
            begin
                fits = 1'b0;
            end
            if (amt[k] > row[23-8*k -: 8])
            begin
                over_need = 1'b1;
            end
            if ($signed({4'd0, amt[k]}) > avail_reg[k])
            begin
                over_avail = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_addr = idx_reg;
        wr_en = 1'b0;
        wr_addr = pid;
        wr_data = '0;
        if (state_reg == S_IDLE && item_reg.operation == OP_LOAD)
        begin
            wr_data = '0;
        end
        if (state_reg == S_DONE && item_reg.operation == OP_LOAD && !load_bad)
        begin
            wr_en = 1'b1;
            wr_data = {hld[0], hld[1], hld[2],
                       amt[0] - hld[0], amt[1] - hld[1], amt[2] - hld[2]};
        end
        if (state_reg == S_REQ && id_ok && !over_need && !over_avail)
        begin
            wr_en = 1'b1;
            wr_data = {row[47:40] + amt[0], row[39:32] + amt[1], row[31:24] + amt[2],
                       row[23:16] - amt[0], row[15:8] - amt[1], row[7:0] - amt[2]};
        end
        if (state_reg == S_ROLL)
        begin
            wr_en = 1'b1;
            wr_data = {row[47:40] - amt[0], row[39:32] - amt[1], row[31:24] - amt[2],
                       row[23:16] + amt[0], row[15:8] + amt[1], row[7:0] + amt[2]};
        end
        // The requester's row is fetched during the compare cycle so that a
        // rollback finds it ready.
        if (state_reg == S_RDREQ || state_reg == S_EVAL || state_reg == S_ROLL)
        begin
            rd_addr = pid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg[0] <= RESET_TOTAL_A;
            total_reg[1] <= RESET_TOTAL_B;
            total_reg[2] <= RESET_TOTAL_C;
            state_reg <= S_IDLE;
            res_v_reg <= 1'b0;
        end
        else
        begin
            res_v_reg <= 1'b0;
            if (cfg_wr && paddr[3:2] <= REG_TOTAL_C)
            begin
                total_reg[paddr[3:2]] <= pwdata[7:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (item.operation == OP_LOAD) ? S_DONE : S_SUM;
                    end
                end
                S_SUM:  state_reg <= (idx_reg == LAST) ? S_SUMW : S_SUM;
                S_SUMW: state_reg <= (item_reg.operation == OP_REQUEST) ? S_RDREQ : S_SCAN;
                S_RDREQ: state_reg <= S_REQ;
                S_REQ:
                begin
                    state_reg <= (!id_ok || over_need || over_avail) ? S_DONE : S_SCAN;
                end
                S_SCAN: state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (!fin_reg[idx_reg] && fits)
                    begin
                        if (len_reg == 4'(PROCESSES - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                    else if (idx_reg == LAST)
                    begin
                        state_reg <= (item_reg.operation == OP_REQUEST) ? S_ROLL : S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_ROLL: state_reg <= S_DONE;
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    res_v_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers (no reset needed).
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg <= item;
                idx_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    avail_reg[k] <= $signed({4'd0, total_reg[k]});
                end
                fin_reg <= '0;
                order_reg <= '0;
                len_reg <= '0;
                status_reg <= ST_OK;
            end
            S_SUM:
            begin
                idx_reg <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
            end
            S_SUMW, S_SCAN, S_RDREQ:
            begin
            end
            S_REQ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    work_reg[k] <= avail_reg[k];
                end
                if (!id_ok || over_need)
                begin
                    status_reg <= ST_OVER_NEED;
                end
                else if (over_avail)
                begin
                    status_reg <= ST_OVER_AVAIL;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        work_reg[k] <= avail_reg[k] - $signed({4'd0, amt[k]});
                    end
                end
            end
            S_EVAL:
            begin
                if (!fin_reg[idx_reg] && fits)
                begin
                    fin_reg[idx_reg] <= 1'b1;
                    order_reg[3*len_reg[2:0] +: 3] <= 3'(idx_reg);
                    len_reg <= len_reg + 4'd1;
                    for (int k = 0; k < 3; k++)
                    begin
                        work_reg[k] <= work_reg[k] + $signed({4'd0, row[47-8*k -: 8]});
                    end
                    idx_reg <= '0;
                end
                else if (idx_reg != LAST)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                else
                begin
                    status_reg <= ST_UNSAFE;
                end
            end
            S_ROLL:
            begin
            end
            S_DONE:
            begin
                if (item_reg.operation == OP_LOAD && load_bad)
                begin
                    status_reg <= ST_BAD_LOAD;
                end
            end
            default:
            begin
            end
        endcase
        // Held sums: the row read in S_SUM arrives in the following cycle.
        if (state_reg == S_SUM && idx_reg != '0 || state_reg == S_SUMW)
        begin
            for (int k = 0; k < 3; k++)
            begin
                avail_reg[k] <= avail_reg[k] - $signed({4'd0, row[47-8*k -: 8]});
            end
        end
        if (state_reg == S_SUMW && item_reg.operation != OP_REQUEST)
        begin
            for (int k = 0; k < 3; k++)
            begin
                work_reg[k] <= avail_reg[k] - $signed({4'd0, row[47-8*k -: 8]});
            end
        end
    end

    assign result_valid = res_v_reg;
    always_comb
    begin
        result.status = status_reg;
        result.safe_order = order_reg;
        result.order_length = len_reg;
        if (status_reg == ST_OVER_NEED || status_reg == ST_OVER_AVAIL
            || status_reg == ST_BAD_LOAD || item_reg.operation == OP_LOAD)
        begin
            result.safe_order = '0;
            result.order_length = '0;
        end
    end

    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy) else $error("result while busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("double result");
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.order_length <= 4'(PROCESSES))
        else $error("length overflow");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy) else $error("accept not tracked");

endmodule

// File: tb/bankers_safety_check_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// bankers_safety_check_unit_test
// Drives load, request and check commands into the deadlock-avoidance unit,
// predicts each status and safe order with a local banker's model and
// compares every result strobe against it. Totals are reprogrammed between
// phases over the APB port.
// ============================================================================
module bankers_safety_check_unit_test;
    import bsc_pkg::*;

    localparam int NPROC = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    bsc_item_t   item;
    logic        result_valid;
    bsc_result_t result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bankers_safety_check_unit #(.PROCESSES(NPROC)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Banker's model state.
    logic [7:0] totals [3];
    logic [7:0] held_rows [NPROC][3];
    logic [7:0] need_rows [NPROC][3];
    bsc_result_t pending_results[$];
    int mismatch_count;
    bit quiet_mode;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int free_units(int k);
        int v;
        v = totals[k];
        for (int p = 0; p < NPROC; p++)
            v -= held_rows[p][k];
        return v;
    endfunction

    function automatic bsc_result_t run_safety();
        bsc_result_t r;
        int work [3];
        bit [NPROC-1:0] done;
        bit found;
        bit fit;
        r = '0;
        done = '0;
        for (int k = 0; k < 3; k++)
            work[k] = free_units(k);
        found = 1'b1;
        while (found)
        begin
            found = 1'b0;
            for (int p = 0; p < NPROC && !found; p++)
            begin
                fit = !done[p];
                for (int k = 0; k < 3; k++)
                    if (int'(need_rows[p][k]) > work[k])
                        fit = 1'b0;
                if (fit)
                begin
                    done[p] = 1'b1;
                    r.safe_order[3*r.order_length +: 3] = p[2:0];
                    r.order_length = r.order_length + 4'd1;
                    for (int k = 0; k < 3; k++)
                        work[k] += held_rows[p][k];
                    found = 1'b1;
                end
            end
        end
        r.status = (r.order_length >= NPROC) ? ST_OK : ST_UNSAFE;
        return r;
    endfunction

    function automatic bsc_result_t predict_banker(bsc_item_t it);
        bsc_result_t r;
        logic [7:0] amt [3];
        logic [7:0] hld [3];
        bit bad;
        bit over_avail;
        r = '0;
        amt = '{it.amount_a, it.amount_b, it.amount_c};
        hld = '{it.held_a, it.held_b, it.held_c};
        if (it.operation == OP_LOAD)
        begin
            bad = 1'b0;
            for (int k = 0; k < 3; k++)
                if (hld[k] > amt[k])
                    bad = 1'b1;
            if (bad)
                r.status = ST_BAD_LOAD;
            else
                for (int k = 0; k < 3; k++)
                begin
                    held_rows[it.process_id][k] = hld[k];
                    need_rows[it.process_id][k] = amt[k] - hld[k];
                end
        end
        else if (it.operation == OP_REQUEST)
        begin
            bad = 1'b0;
            over_avail = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                if (amt[k] > need_rows[it.process_id][k])
                    bad = 1'b1;
                if (int'(amt[k]) > free_units(k))
                    over_avail = 1'b1;
            end
            if (bad)
                r.status = ST_OVER_NEED;
            else if (over_avail)
                r.status = ST_OVER_AVAIL;
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    held_rows[it.process_id][k] += amt[k];
                    need_rows[it.process_id][k] -= amt[k];
                end
                r = run_safety();
                if (r.status == ST_UNSAFE)
                    for (int k = 0; k < 3; k++)
                    begin
                        held_rows[it.process_id][k] -= amt[k];
                        need_rows[it.process_id][k] += amt[k];
                    end
            end
        end
        else
            r = run_safety();
        return r;
    endfunction

    // Result checker: a result is on the port for exactly one cycle.
    always @(posedge clk)
    begin
        bsc_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status || result.safe_order !== want.safe_order
                    || result.order_length !== want.order_length)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result: expected st=%0d ord=%h len=%0d",
                                  " got st=%0d ord=%h len=%0d"},
                                 want.status, want.safe_order, want.order_length,
                                 result.status, result.safe_order, result.order_length);
                end
            end
        end
    end

    // Values read just after the clock rises are still those sampled as it rose.
    task automatic send_command(bsc_item_t it);
        if (!quiet_mode)
            while ($urandom_range(99) < 8)
                @(posedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_banker(it));
        start <= 1'b0;
        // The unit is busy in the cycle after a transfer, so nothing is lost.
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_total(logic [1:0] idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        totals[idx] = value;
    endtask

    task automatic set_totals(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        drain_results();
        write_total(REG_TOTAL_A, a);
        write_total(REG_TOTAL_B, b);
        write_total(REG_TOTAL_C, c);
    endtask

    function automatic bsc_item_t make_cmd(logic [1:0] op, int pid,
                                           int a, int b, int c,
                                           int ha, int hb, int hc);
        bsc_item_t it;
        it = '{op, 3'(pid), 8'(a), 8'(b), 8'(c), 8'(ha), 8'(hb), 8'(hc)};
        return it;
    endfunction

    // Small amounts keep the safety test interesting against small totals.
    function automatic logic [7:0] small_amt(int top);
        return 8'($urandom_range(top));
    endfunction

    task automatic test_directed();
        // Classic textbook table under reset totals 10/5/7.
        send_command(make_cmd(OP_LOAD, 0, 7, 5, 3, 0, 1, 0));
        send_command(make_cmd(OP_LOAD, 1, 3, 2, 2, 2, 0, 0));
        send_command(make_cmd(OP_LOAD, 2, 9, 0, 2, 3, 0, 2));
        send_command(make_cmd(OP_LOAD, 3, 2, 2, 2, 2, 1, 1));
        send_command(make_cmd(OP_LOAD, 4, 4, 3, 3, 0, 0, 2));
        send_command(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_REQUEST, 1, 1, 0, 2, 0, 0, 0));
        send_command(make_cmd(OP_REQUEST, 4, 3, 3, 0, 0, 0, 0));
        send_command(make_cmd(OP_REQUEST, 0, 0, 2, 0, 0, 0, 0));
        send_command(make_cmd(OP_REQUEST, 0, 255, 255, 255, 0, 0, 0));
        send_command(make_cmd(OP_LOAD, 7, 3, 3, 3, 4, 0, 0));
        send_command(make_cmd(OP_LOAD, 7, 255, 255, 255, 255, 255, 255));
        send_command(make_cmd(OP_SPARE, 5, 255, 255, 255, 255, 255, 255));
        send_command(make_cmd(OP_LOAD, 7, 255, 255, 255, 0, 0, 0));
        send_command(make_cmd(OP_REQUEST, 7, 1, 1, 1, 0, 0, 0));
        send_command(make_cmd(OP_LOAD, 7, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int count, int top);
        bsc_item_t it;
        logic [63:0] noise;
        logic [7:0] c0, c1, c2;
        for (int n = 0; n < count; n++)
        begin
            noise = {$urandom, $urandom};
            it = noise[$bits(bsc_item_t)-1:0];
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    c0 = small_amt(top);
                    c1 = small_amt(top);
                    c2 = small_amt(top);
                    it = make_cmd(OP_LOAD, it.process_id, c0, c1, c2,
                                  8'($urandom_range(c0)), 8'($urandom_range(c1)),
                                  8'($urandom_range(c2)));
                end
                3, 4, 5, 6:
                    it = make_cmd(OP_REQUEST, it.process_id, small_amt(top / 2 + 1),
                                  small_amt(top / 2 + 1), small_amt(top / 2 + 1), it.held_a,
                                  it.held_b, it.held_c);
                7:
                    it.operation = ($urandom_range(1) != 0) ? OP_SPARE : OP_CHECK;
                default: ; // unconstrained noise, full field values
            endcase
            send_command(it);
        end
    endtask

    task automatic test_pause_until_drained();
        drain_results();
        send_command(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    initial
    begin
        totals = '{RESET_TOTAL_A, RESET_TOTAL_B, RESET_TOTAL_C};
        held_rows = '{default: '{default: 8'd0}};
        need_rows = '{default: '{default: 8'd0}};
        mismatch_count = 0;
        quiet_mode = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200, 6);
        test_pause_until_drained();
        set_totals(8'd20, 8'd15, 8'd12);
        quiet_mode = 1'b1;
        test_random(150, 8);
        quiet_mode = 1'b0;
        set_totals(8'd0, 8'd0, 8'd0);
        test_random(100, 3);
        set_totals(8'd255, 8'd255, 8'd255);
        test_random(200, 120);
        set_totals(8'd6, 8'd9, 8'd4);
        test_random(200, 5);
        drain_results();
        repeat (100) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("bankers_safety_check_unit: match");
        else
            $display("bankers_safety_check_unit: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("bankers_safety_check_unit: mismatch");
        $finish;
    end
endmodule

// File: bankers_safety_check_unit.f
hdl/bsc_pkg.sv
hdl/bankers_safety_check_unit.sv
tb/bankers_safety_check_unit_test.sv
